// ----- hw/rtl/spiral_order_matrix_reader_macros.svh -----
// assertion macros for the spiral order matrix reader
// clocked by clk and disabled while rst_n is low; no other dependencies
`ifndef SPIRAL_ORDER_MATRIX_READER_MACROS_SVH
`define SPIRAL_ORDER_MATRIX_READER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SOMR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spiral reader assertion failed");
// next-cycle implication
`define SOMR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spiral reader assertion failed");
`else
`define SOMR_ASSERT_NOW(lbl, ante, cons)
`define SOMR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/somr_pkg.sv -----
// shared types and codes for the spiral order matrix reader
// no dependencies
package somr_pkg;

  localparam int VALUE_W   = 32;
  localparam int DIM_W     = 5;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  // input function codes (carried in tuser)
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // side of the current ring being walked
  typedef enum logic [3:0] {
    LEG_TOP    = 4'b0001,
    LEG_RIGHT  = 4'b0010,
    LEG_BOTTOM = 4'b0100,
    LEG_LEFT   = 4'b1000
  } leg_t;

endpackage

// ----- hw/rtl/somr_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies; read data holds while rd_en is low
module somr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/spiral_order_matrix_reader.sv -----
// Spiral order matrix reader. Write transactions (tuser = 0) load a rows x cols
// matrix row-major into an internal ram; once rows*cols words are in, read
// transactions (tuser = 1) return one element each in clockwise spiral order,
// tlast on the final one, after which a new matrix may be loaded. A read with
// no loaded matrix returns tuser (ok) = 0 and tdata = 0. Each read result
// passes the registered ram read and then the output register: the position
// logic and ram address multiply settle in the accepting cycle, the ram read is
// registered at that edge, and the output register takes the data once it is
// free. One transaction per cycle is sustained while results are taken; the
// ram needs no clearing pass.
// Depends on somr_pkg, somr_ram and spiral_order_matrix_reader_macros.svh.
`include "spiral_order_matrix_reader_macros.svh"

module spiral_order_matrix_reader #(
  parameter int MAX_ROWS   = 16,
  parameter int MAX_COLS   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [somr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [somr_pkg::DIM_W-1:0]     cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [somr_pkg::VALUE_W-1:0]   in_tdata,   // value
  input  logic                           in_tuser,   // func
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [somr_pkg::VALUE_W-1:0]   out_tdata,  // element
  output logic                           out_tlast,  // last
  output logic                           out_tuser   // ok
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LCW   = $clog2(DEPTH + 1);
  localparam int MAXD  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int NW    = $clog2(MAXD + 1);
  localparam int PW    = $clog2(MAXD + 1);
  localparam int IW    = $clog2(MAXD + 1) + 1;
  localparam int LW    = IW + NW;

  // configuration
  logic [somr_pkg::DIM_W-1:0] rows_r, cols_r;

  // traversal state
  logic                  reading_r, reading_nxt;
  logic [LCW-1:0]        load_count_r, load_count_nxt;
  logic [NW-1:0]         held_cols_r, held_cols_nxt;
  logic signed [IW-1:0]  top_r, bot_r, left_r, right_r;
  logic signed [IW-1:0]  top_nxt, bot_nxt, left_nxt, right_nxt;
  somr_pkg::leg_t        leg_r, leg_nxt;
  logic [PW-1:0]         pos_r, pos_nxt;

  // read stage and output register
  logic                  p1_valid_r, p1_valid_nxt;
  logic                  p1_ok_r, p1_ok_nxt;
  logic                  p1_last_r, p1_last_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [somr_pkg::VALUE_W-1:0] out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_ok_r, out_ok_nxt;

  logic                  accept, p1_move;
  logic [NW-1:0]         nr, nc;
  logic [2*NW-1:0]       prod;
  logic [LCW-1:0]        cnt_inc;
  logic signed [IW-1:0]  len, pos_inc, r_coord, c_coord;
  logic [LW-1:0]         lin;
  logic                  ram_we, ram_re, step_done;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [63:0]           wr_wide;
  logic signed [63:0]    rd_ext;

  assign p1_move   = p1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !p1_valid_r || !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // size clamp and element count
  assign nr = (rows_r == '0) ? NW'(1) :
              (32'(rows_r) > MAX_ROWS) ? NW'(MAX_ROWS) : NW'(rows_r);
  assign nc = (cols_r == '0) ? NW'(1) :
              (32'(cols_r) > MAX_COLS) ? NW'(MAX_COLS) : NW'(cols_r);
  assign prod    = {{NW{1'b0}}, nr} * {{NW{1'b0}}, nc};
  assign cnt_inc = load_count_r + LCW'(1);

  // current leg length and coordinates
  always_comb begin
    case (leg_r)
      somr_pkg::LEG_TOP: begin
        len = right_r - left_r + IW'(1);
        r_coord = top_r;
        c_coord = left_r + IW'(pos_r);
      end
      somr_pkg::LEG_RIGHT: begin
        len = bot_r - top_r + IW'(1);
        r_coord = top_r + IW'(pos_r);
        c_coord = right_r;
      end
      somr_pkg::LEG_BOTTOM: begin
        len = right_r - left_r + IW'(1);
        r_coord = bot_r;
        c_coord = right_r - IW'(pos_r);
      end
      default: begin
        len = bot_r - top_r + IW'(1);
        r_coord = bot_r - IW'(pos_r);
        c_coord = left_r;
      end
    endcase
  end

  assign pos_inc = IW'(pos_r) + IW'(1);
  assign lin = LW'(r_coord[IW-2:0]) * LW'(held_cols_r) + LW'(c_coord[IW-2:0]);

  assign wr_wide   = 64'(in_tdata);
  assign ram_wdata = wr_wide[DATA_WIDTH-1:0];
  assign ram_we    = accept && (in_tuser == somr_pkg::FUNC_WRITE) && !reading_r;
  assign ram_re    = accept && (in_tuser == somr_pkg::FUNC_READ) && reading_r;

  always_comb begin
    reading_nxt    = reading_r;
    load_count_nxt = load_count_r;
    held_cols_nxt  = held_cols_r;
    top_nxt        = top_r;
    bot_nxt        = bot_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    leg_nxt        = leg_r;
    pos_nxt        = pos_r;
    step_done      = 1'b0;
    p1_valid_nxt   = p1_move ? 1'b0 : p1_valid_r;
    p1_ok_nxt      = p1_ok_r;
    p1_last_nxt    = p1_last_r;

    if (ram_we) begin
      load_count_nxt = cnt_inc;
      if (32'(cnt_inc) >= 32'(prod)) begin
        reading_nxt   = 1'b1;
        held_cols_nxt = nc;
        top_nxt       = '0;
        left_nxt      = '0;
        bot_nxt       = IW'(nr) - IW'(1);
        right_nxt     = IW'(nc) - IW'(1);
        leg_nxt       = somr_pkg::LEG_TOP;
        pos_nxt       = '0;
      end
    end

    if (accept && (in_tuser == somr_pkg::FUNC_READ)) begin
      p1_valid_nxt = 1'b1;
      p1_ok_nxt    = reading_r;
      p1_last_nxt  = 1'b0;
      if (reading_r) begin
        if (pos_inc < len) begin
          pos_nxt = PW'(pos_inc);
        end else begin
          // leg finished: shrink that side, turn clockwise
          pos_nxt = '0;
          case (leg_r)
            somr_pkg::LEG_TOP: begin
              top_nxt = top_r + IW'(1);
              leg_nxt = somr_pkg::LEG_RIGHT;
            end
            somr_pkg::LEG_RIGHT: begin
              right_nxt = right_r - IW'(1);
              leg_nxt   = somr_pkg::LEG_BOTTOM;
            end
            somr_pkg::LEG_BOTTOM: begin
              bot_nxt = bot_r - IW'(1);
              leg_nxt = somr_pkg::LEG_LEFT;
            end
            default: begin
              left_nxt = left_r + IW'(1);
              leg_nxt  = somr_pkg::LEG_TOP;
            end
          endcase
          step_done = (top_nxt > bot_nxt) || (left_nxt > right_nxt);
        end
        p1_last_nxt = step_done;
        if (step_done) begin
          reading_nxt    = 1'b0;
          load_count_nxt = '0;
        end
      end
    end
  end

  assign rd_ext = 64'(signed'(ram_rdata));

  always_comb begin
    out_valid_nxt = (out_valid_r && !out_tready) || p1_move;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_ok_nxt    = out_ok_r;
    if (p1_move) begin
      out_data_nxt = p1_ok_r ? rd_ext[somr_pkg::VALUE_W-1:0] : '0;
      out_last_nxt = p1_last_r;
      out_ok_nxt   = p1_ok_r;
    end
  end

  somr_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (load_count_r[AW-1:0]),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (lin[AW-1:0]),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r       <= somr_pkg::DIM_W'(16);
      cols_r       <= somr_pkg::DIM_W'(16);
      reading_r    <= 1'b0;
      load_count_r <= '0;
      held_cols_r  <= NW'(1);
      top_r        <= '0;
      bot_r        <= '0;
      left_r       <= '0;
      right_r      <= '0;
      leg_r        <= somr_pkg::LEG_TOP;
      pos_r        <= '0;
      p1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en && (cfg_index == somr_pkg::REG_ROWS)) begin
        rows_r <= cfg_wdata;
      end
      if (cfg_wr_en && (cfg_index == somr_pkg::REG_COLS)) begin
        cols_r <= cfg_wdata;
      end
      reading_r    <= reading_nxt;
      load_count_r <= load_count_nxt;
      held_cols_r  <= held_cols_nxt;
      top_r        <= top_nxt;
      bot_r        <= bot_nxt;
      left_r       <= left_nxt;
      right_r      <= right_nxt;
      leg_r        <= leg_nxt;
      pos_r        <= pos_nxt;
      p1_valid_r   <= p1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p1_ok_r    <= p1_ok_nxt;
    p1_last_r  <= p1_last_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ok_r;

  `SOMR_ASSERT_NOW(a_last_needs_ok, out_valid_r && out_last_r, out_ok_r)
  `SOMR_ASSERT_NOW(a_no_ok_zero, out_valid_r && !out_ok_r, (out_data_r == '0) && !out_last_r)
  `SOMR_ASSERT_NOW(a_ring_nonempty, reading_r, (top_r <= bot_r) && (left_r <= right_r))
  `SOMR_ASSERT_NOW(a_pos_in_leg, reading_r, IW'(pos_r) < len)
  `SOMR_ASSERT_NOW(a_stall_blocks_input, p1_valid_r && out_valid_r && !out_tready, !in_tready)
  `SOMR_ASSERT_NEXT(a_drain_clears_count, ram_re && step_done, !reading_r && (load_count_r == '0))

endmodule
